[src/spmv_pkg.sv]
// Shared types and constants for the CSR sparse matrix-vector multiply unit.
// Used by spmv_vec_store and csr_sparse_matrix_vector_multiply_unit; no dependencies.
package spmv_pkg;

    localparam int VECTOR_DEPTH = 4096;
    localparam int VALUE_WIDTH  = 32;
    localparam int ADDR_W       = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int INDEX_W      = 12;
    localparam int IN_VALUE_W   = 32;
    localparam int SUM_W        = 32;
    localparam int ROW_W        = 16;

    typedef logic [VALUE_WIDTH-1:0] val_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [ROW_W-1:0]       row_t;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_NONZERO = 2'd1,
        OP_EMPTY   = 2'd2
    } op_t;

    // One access per cycle to the vector store: a write for a load or a read for a nonzero.
    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        addr_t addr;
        val_t  wdata;
    } mem_req_t;

endpackage

[src/csr_sparse_matrix_vector_multiply_unit.sv]
// Top level of the CSR sparse matrix-vector multiply unit.
// Depends on spmv_pkg and spmv_vec_store.
//
// Load the dense vector first (operation load, one element per item), then stream the
// matrix nonzeros in CSR row order; a nonzero with row_end set, or an empty-row item,
// produces one result with the wrapped row sum and its row number. A load clears the
// accumulator and the row number. The unit takes one item per cycle while no finished
// result waits on m_ready: the path is a three-stage pipeline (vector store read,
// multiply, accumulate into the output register), so an item passes v1_reg and v2_reg
// before m_valid can rise with its result. The single vector store port is used by at
// most one item per cycle, and the pipeline stalls as a whole only while a finished
// result waits on m_ready.
module csr_sparse_matrix_vector_multiply_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic [spmv_pkg::INDEX_W-1:0]        s_index,
    input  logic signed [spmv_pkg::IN_VALUE_W-1:0] s_value,
    input  logic                                s_row_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [spmv_pkg::SUM_W-1:0]   m_row_sum,
    output logic [spmv_pkg::ROW_W-1:0]          m_row_number
);

    logic                adv;
    spmv_pkg::op_t       s_op;
    logic                s_in_range;
    spmv_pkg::mem_req_t  mem_req;
    spmv_pkg::val_t      rd_data;
    spmv_pkg::val_t      s_value_ext;

    // stage 1: vector element read in flight
    logic                v1_reg;
    spmv_pkg::op_t       op1_reg;
    spmv_pkg::val_t      val1_reg;
    logic                last1_reg;
    logic                hit1_reg;

    // stage 2: product registered
    logic                v2_reg;
    spmv_pkg::op_t       op2_reg;
    spmv_pkg::val_t      prod2_reg;
    spmv_pkg::val_t      prod2_next;
    logic                last2_reg;

    // accumulate state and output register
    spmv_pkg::val_t      acc_reg;
    spmv_pkg::val_t      acc_next;
    spmv_pkg::row_t      row_cnt_reg;
    spmv_pkg::row_t      row_cnt_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [spmv_pkg::SUM_W-1:0] row_sum_reg;
    logic [spmv_pkg::SUM_W-1:0] row_sum_next;
    spmv_pkg::row_t      row_number_reg;
    spmv_pkg::row_t      row_number_next;
    spmv_pkg::val_t      sum;

    assign adv        = !m_valid_reg || m_ready;
    assign s_ready    = adv;
    assign s_op       = spmv_pkg::op_t'(s_operation);
    assign s_in_range = 32'(s_index) < spmv_pkg::VECTOR_DEPTH;
    assign s_value_ext = spmv_pkg::val_t'(s_value);

    always_comb begin
        mem_req.wr_en = adv && s_valid && (s_op == spmv_pkg::OP_LOAD) && s_in_range;
        mem_req.rd_en = adv && s_valid && (s_op == spmv_pkg::OP_NONZERO) && s_in_range;
        mem_req.addr  = spmv_pkg::ADDR_W'(s_index);
        mem_req.wdata = s_value_ext;
    end

    spmv_vec_store u_vec_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Out-of-range column reads as zero.
    assign prod2_next = hit1_reg ? spmv_pkg::val_t'(val1_reg * rd_data) : '0;
    assign sum        = acc_reg + prod2_reg;

    always_comb begin
        acc_next        = acc_reg;
        row_cnt_next    = row_cnt_reg;
        m_valid_next    = 1'b0;
        row_sum_next    = row_sum_reg;
        row_number_next = row_number_reg;
        if (v2_reg) begin
            case (op2_reg)
                spmv_pkg::OP_LOAD: begin
                    acc_next     = '0;
                    row_cnt_next = '0;
                end
                spmv_pkg::OP_NONZERO: begin
                    if (last2_reg) begin
                        m_valid_next    = 1'b1;
                        row_sum_next    = spmv_pkg::SUM_W'(sum);
                        row_number_next = row_cnt_reg;
                        row_cnt_next    = row_cnt_reg + 1'b1;
                        acc_next        = '0;
                    end else begin
                        acc_next = sum;
                    end
                end
                spmv_pkg::OP_EMPTY: begin
                    m_valid_next    = 1'b1;
                    row_sum_next    = '0;
                    row_number_next = row_cnt_reg;
                    row_cnt_next    = row_cnt_reg + 1'b1;
                    acc_next        = '0;
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            row_cnt_reg <= '0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg        <= s_op;
            val1_reg       <= s_value_ext;
            last1_reg      <= s_row_end;
            hit1_reg       <= s_in_range;
            op2_reg        <= op1_reg;
            prod2_reg      <= prod2_next;
            last2_reg      <= last1_reg;
            row_sum_reg    <= row_sum_next;
            row_number_reg <= row_number_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_row_sum    = row_sum_reg;
    assign m_row_number = row_number_reg;

    // A new result needs an item in the accumulate stage.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v2_reg))
        else $error("result appeared without an item in the accumulate stage");

    // A load clears the running sum and the row number.
    a_load_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && v2_reg && (op2_reg == spmv_pkg::OP_LOAD))
        |=> (acc_reg == '0) && (row_cnt_reg == '0))
        else $error("load did not clear accumulator and row counter");

    // A stalled pipeline keeps its accumulate state.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(acc_reg) && $stable(row_cnt_reg) && $stable(v2_reg))
        else $error("accumulate state changed during a stall");

endmodule

[src/spmv_vec_store.sv]
// Dense vector store: single-port synchronous memory with registered read data.
// Depends on spmv_pkg.
module spmv_vec_store (
    input  logic               aclk,
    input  spmv_pkg::mem_req_t req,
    output spmv_pkg::val_t     rd_data
);

    spmv_pkg::val_t mem [spmv_pkg::VECTOR_DEPTH];
    spmv_pkg::val_t rd_data_reg;

    // Read data holds while no read is issued, so a stalled pipeline keeps it.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
